// ----- src/dde_pkg.sv -----
// shared constants, types and state encodings of the drawdown event detector
package dde_pkg;

	localparam int PRICE_BITS  = 32;
	localparam int INDEX_BITS  = 40;
	localparam int TIME_BITS   = 64;
	localparam int THR_BITS    = 14;
	localparam int PROD_BITS   = PRICE_BITS + THR_BITS;
	localparam int CNT_BITS    = $clog2(THR_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	localparam logic [THR_BITS-1:0] BP_SCALE      = THR_BITS'(10000);
	localparam logic [THR_BITS-1:0] THR_RESET_VAL = THR_BITS'(200);

	typedef struct packed {
		logic [TIME_BITS-1:0]  peak_ts;
		logic [TIME_BITS-1:0]  trough_ts;
		logic [PRICE_BITS-1:0] peak_level;
		logic [PRICE_BITS-1:0] bottom_level;
		logic [PROD_BITS-1:0]  dividend;
		logic [INDEX_BITS-1:0] start_index;
		logic [INDEX_BITS-1:0] duration;
	} event_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_UPD
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} bk_state_t;

endpackage

// ----- src/dde_front.sv -----
// front end: takes ticks, tracks peak and bottom, queues crash events
module dde_front import dde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [THR_BITS-1:0]   thr,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PRICE_BITS-1:0] tick_price,
	input  logic [TIME_BITS-1:0]  tick_time,
	input  logic                  is_last,
	output logic                  push,
	output event_t                push_ev,
	input  logic                  q_full
);

	fr_state_t fr_state_q, fr_state_d;

	logic [PRICE_BITS-1:0] peak_val_q;
	logic [TIME_BITS-1:0]  peak_ts_q;
	logic [INDEX_BITS-1:0] peak_idx_q;
	logic [PRICE_BITS-1:0] bot_val_q;
	logic [TIME_BITS-1:0]  bot_time_q;
	logic                  in_dd_q;
	logic [PROD_BITS-1:0]  prev_prod_q;
	logic                  prev_below_q;
	logic [INDEX_BITS-1:0] tick_idx_q;

	logic [PRICE_BITS-1:0] price_s1;
	logic [TIME_BITS-1:0]  time_s1;
	logic                  last_s1;

	logic [PRICE_BITS-1:0] price_s2;
	logic [TIME_BITS-1:0]  time_s2;
	logic                  last_s2;
	logic [INDEX_BITS-1:0] idx_s2;
	logic [PROD_BITS-1:0]  prod_s2;
	logic [PROD_BITS-1:0]  thrpk_s2;
	logic                  newpk_s2;
	logic                  below_s2;

	logic                  accept;
	logic                  go;
	logic                  ev_peak;
	logic                  ev_last;
	logic                  ex;
	logic                  dd_eff;
	logic [PRICE_BITS-1:0] nb_val;
	logic [TIME_BITS-1:0]  nb_time;
	logic [PRICE_BITS-1:0] diff;
	logic [PROD_BITS-1:0]  prod;
	logic [PROD_BITS-1:0]  thrpk;

	// product stage
	always_comb begin
		diff  = peak_val_q - price_s1;
		prod  = PROD_BITS'(diff) * PROD_BITS'(BP_SCALE);
		thrpk = PROD_BITS'(thr) * PROD_BITS'(peak_val_q);
	end

	// update stage classification
	always_comb begin
		ev_peak = newpk_s2 && in_dd_q && prev_below_q && (prev_prod_q > thrpk_s2);
		ex      = below_s2 && (prod_s2 > thrpk_s2);
		ev_last = last_s2 && ex;
		dd_eff  = in_dd_q && !newpk_s2;
		if (!dd_eff || (price_s2 < bot_val_q)) begin
			nb_val  = price_s2;
			nb_time = time_s2;
		end else begin
			nb_val  = bot_val_q;
			nb_time = bot_time_q;
		end
	end

	always_comb begin
		go       = (fr_state_q == FR_UPD) && !((ev_peak || ev_last) && q_full);
		in_stall = !((fr_state_q == FR_IDLE) || go);
		accept   = in_valid && !in_stall;
		push     = go && (ev_peak || ev_last);

		push_ev.peak_ts     = peak_ts_q;
		push_ev.peak_level  = peak_val_q;
		push_ev.start_index = peak_idx_q;
		push_ev.duration    = idx_s2 - peak_idx_q;
		if (ev_peak) begin
			push_ev.trough_ts    = bot_time_q;
			push_ev.bottom_level = bot_val_q;
			push_ev.dividend     = prev_prod_q;
		end else begin
			push_ev.trough_ts    = nb_time;
			push_ev.bottom_level = nb_val;
			push_ev.dividend     = prod_s2;
		end

		fr_state_d = fr_state_q;
		case (fr_state_q)
			FR_IDLE: begin
				if (accept) fr_state_d = FR_MUL;
			end
			FR_MUL: begin
				fr_state_d = FR_UPD;
			end
			FR_UPD: begin
				if (go) fr_state_d = accept ? FR_MUL : FR_IDLE;
			end
			default: begin
				fr_state_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_state_q <= FR_IDLE;
		end else begin
			fr_state_q <= fr_state_d;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_val_q   <= '0;
			peak_ts_q    <= '0;
			peak_idx_q   <= '0;
			bot_val_q    <= '0;
			bot_time_q   <= '0;
			in_dd_q      <= 1'b0;
			prev_prod_q  <= '0;
			prev_below_q <= 1'b0;
			tick_idx_q   <= '0;
		end else if (go) begin
			if (last_s2) begin
				peak_val_q   <= '0;
				peak_ts_q    <= '0;
				peak_idx_q   <= '0;
				bot_val_q    <= '0;
				bot_time_q   <= '0;
				in_dd_q      <= 1'b0;
				prev_prod_q  <= '0;
				prev_below_q <= 1'b0;
				tick_idx_q   <= '0;
			end else begin
				if (newpk_s2) begin
					peak_val_q <= price_s2;
					peak_ts_q  <= time_s2;
					peak_idx_q <= idx_s2;
					bot_val_q  <= price_s2;
					in_dd_q    <= 1'b0;
				end
				if (ex && !dd_eff) begin
					in_dd_q    <= 1'b1;
					bot_val_q  <= price_s2;
					bot_time_q <= time_s2;
				end else if (dd_eff && (price_s2 < bot_val_q)) begin
					bot_val_q  <= price_s2;
					bot_time_q <= time_s2;
				end
				prev_prod_q  <= prod_s2;
				prev_below_q <= below_s2;
				tick_idx_q   <= idx_s2;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			price_s1 <= tick_price;
			time_s1  <= tick_time;
			last_s1  <= is_last;
		end
		if (fr_state_q == FR_MUL) begin
			price_s2 <= price_s1;
			time_s2  <= time_s1;
			last_s2  <= last_s1;
			idx_s2   <= tick_idx_q + INDEX_BITS'(1);
			prod_s2  <= prod;
			thrpk_s2 <= thrpk;
			newpk_s2 <= price_s1 > peak_val_q;
			below_s2 <= price_s1 < peak_val_q;
		end
	end

endmodule

// ----- src/dde_queue.sv -----
// short event queue between front and back end
module dde_queue import dde_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_ev,
	output logic   full,
	input  logic   pop,
	output event_t pop_ev,
	output logic   empty
);

	event_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  cnt_q;

	always_comb begin
		full   = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
		empty  = cnt_q == '0;
		pop_ev = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

endmodule

// ----- src/dde_back.sv -----
// back end: bit-serial basis point divide and result output register
module dde_back import dde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  event_t                pop_ev,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TIME_BITS-1:0]  peak_ts,
	output logic [TIME_BITS-1:0]  trough_ts,
	output logic [PRICE_BITS-1:0] peak_level,
	output logic [PRICE_BITS-1:0] bottom_level,
	output logic [THR_BITS-1:0]   drop_bp,
	output logic [INDEX_BITS-1:0] start_index,
	output logic [INDEX_BITS-1:0] span_ticks
);

	bk_state_t bk_state_q, bk_state_d;

	event_t                ev_q;
	logic [PRICE_BITS-1:0] rem_q;
	logic [THR_BITS-1:0]   lo_q;
	logic [THR_BITS-1:0]   quo_q;
	logic [CNT_BITS-1:0]   cnt_q;

	logic [PRICE_BITS:0]   ext;
	logic [PRICE_BITS:0]   trial;
	logic                  ge;
	logic                  step_done;

	always_comb begin
		ext       = {rem_q, lo_q[THR_BITS-1]};
		trial     = ext - {1'b0, ev_q.peak_level};
		ge        = !trial[PRICE_BITS];
		step_done = cnt_q == CNT_BITS'(THR_BITS - 1);

		pop       = (bk_state_q == BK_IDLE) && !q_empty;
		out_valid = bk_state_q == BK_OUT;

		bk_state_d = bk_state_q;
		case (bk_state_q)
			BK_IDLE: begin
				if (!q_empty) bk_state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_done) bk_state_d = BK_OUT;
			end
			BK_OUT: begin
				if (!out_stall) bk_state_d = BK_IDLE;
			end
			default: begin
				bk_state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_state_q <= BK_IDLE;
			cnt_q      <= '0;
		end else begin
			bk_state_q <= bk_state_d;
			if (pop) begin
				cnt_q <= '0;
			end else if (bk_state_q == BK_DIV) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q  <= pop_ev;
			rem_q <= pop_ev.dividend[PROD_BITS-1:THR_BITS];
			lo_q  <= pop_ev.dividend[THR_BITS-1:0];
			quo_q <= '0;
		end else if (bk_state_q == BK_DIV) begin
			rem_q <= ge ? trial[PRICE_BITS-1:0] : ext[PRICE_BITS-1:0];
			lo_q  <= {lo_q[THR_BITS-2:0], 1'b0};
			quo_q <= {quo_q[THR_BITS-2:0], ge};
		end
	end

	always_comb begin
		peak_ts      = ev_q.peak_ts;
		trough_ts    = ev_q.trough_ts;
		peak_level   = ev_q.peak_level;
		bottom_level = ev_q.bottom_level;
		drop_bp      = quo_q;
		start_index  = ev_q.start_index;
		span_ticks   = ev_q.duration;
	end

endmodule

// ----- src/drawdown_event_detector.sv -----
// top level of the drawdown event detector
// a tick passes through the front end's product stage, then its state update stage;
// a new tick is taken only as the previous one leaves its state update, set by the peak dependency between ticks
// an event's drop is computed by the 14-step serial divider in the back end before the event leaves;
// events drain through a 2-deep queue, and the back end pops the next event only after the last one is output
// reset clears the stream state and loads the threshold with 200 basis points
module drawdown_event_detector import dde_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [THR_BITS-1:0]   cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PRICE_BITS-1:0] tick_price,
	input  logic [TIME_BITS-1:0]  tick_time,
	input  logic                  is_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [TIME_BITS-1:0]  peak_ts,
	output logic [TIME_BITS-1:0]  trough_ts,
	output logic [PRICE_BITS-1:0] peak_level,
	output logic [PRICE_BITS-1:0] bottom_level,
	output logic [THR_BITS-1:0]   drop_bp,
	output logic [INDEX_BITS-1:0] start_index,
	output logic [INDEX_BITS-1:0] span_ticks
);

	logic [THR_BITS-1:0] thr_q;
	logic                push;
	event_t              push_ev;
	logic                q_full;
	logic                pop;
	event_t              pop_ev;
	logic                q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET_VAL;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	dde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.tick_price (tick_price),
		.tick_time  (tick_time),
		.is_last    (is_last),
		.push       (push),
		.push_ev    (push_ev),
		.q_full     (q_full)
	);

	dde_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ev (push_ev),
		.full    (q_full),
		.pop     (pop),
		.pop_ev  (pop_ev),
		.empty   (q_empty)
	);

	dde_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.pop_ev       (pop_ev),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.peak_ts      (peak_ts),
		.trough_ts    (trough_ts),
		.peak_level   (peak_level),
		.bottom_level (bottom_level),
		.drop_bp      (drop_bp),
		.start_index  (start_index),
		.span_ticks   (span_ticks)
	);

endmodule
